FILE: hw/rtl/predictive_fridge_cool_heat_control_assert.svh
// assertion macros used by the checker file
`ifndef PREDICTIVE_FRIDGE_COOL_HEAT_CONTROL_ASSERT_SVH
`define PREDICTIVE_FRIDGE_COOL_HEAT_CONTROL_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PFCH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfch assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PFCH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfch assertion failed");

`endif

FILE: hw/rtl/pfchc_pkg.sv
package pfchc_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned RATE_W  = 20;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned PROD_W  = RATE_W + MUL_B_W;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_COOL = 2'd1;
  localparam logic [1:0] MODE_HEAT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_DIFF     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_DIFF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COOL_MIN_OFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_MIN_OFF  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COOL_MIN_ON   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COOL_MAX_ON   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_MAX_WAIT = 3'd7;

  localparam int unsigned PEAK_MAX_TIME_DEF = 1200;

  localparam logic [RATE_W-1:0] RATE_MIN   = 20'd50;
  localparam logic [RATE_W-1:0] RATE_MAX   = 20'd1000000;
  localparam logic [RATE_W-1:0] RATE_RESET = 20'd20000;

  // divisors: seconds-per-hour times ten, and the 1/10000 factor scale
  localparam logic [15:0] DIV_DROP  = 16'd36000;
  localparam logic [15:0] DIV_SCALE = 16'd10000;
  localparam logic [18:0] F_BASE    = 19'd12000;
  localparam logic [18:0] F_CAP     = 19'd15000;

  localparam logic [1:0] OP_DROP = 2'd0;
  localparam logic [1:0] OP_UP   = 2'd1;
  localparam logic [1:0] OP_DOWN = 2'd2;

  // floor(duty * 255 / 100) by reciprocal 5243 / 2^19, saturated at 255
  function automatic logic [7:0] heater_from_duty(input logic [6:0] duty);
    logic [14:0] x;
    logic [27:0] p;
    logic [8:0]  q;
    x = 15'({duty, 8'd0}) - 15'(duty);
    p = 28'(x) * 28'd5243;
    q = p[27:19];
    return q[8] ? 8'hFF : q[7:0];
  endfunction

endpackage

FILE: hw/rtl/predictive_fridge_cool_heat_control.sv
// sequence: a tick without arithmetic goes wait, eval, out; when the predicted
//   drop or the estimator update runs: wait, eval, 16 multiply steps, 36 divide steps, post, out
// throughput: one request at a time, the next accepted once the result is loaded
// the serial multiplier and restoring divider make the arithmetic path the long one
// reset: synchronous active-low rst_n; idle/idle, estimator 20000, stamps 0
module predictive_fridge_cool_heat_control #(
  parameter int unsigned PEAK_MAX_TIME = pfchc_pkg::PEAK_MAX_TIME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_now_seconds,
  input  logic signed [15:0] in_fridge_temp,
  input  logic signed [15:0] in_beer_temp,
  input  logic signed [15:0] in_target_temp,
  input  logic        in_peak_seen,
  input  logic [6:0]  in_heat_duty,
  input  logic        in_duty_fresh,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_mode,
  output logic [1:0]  out_prior_mode,
  output logic        out_compressor_on,
  output logic [7:0]  out_heater_level,
  output logic        out_heat_loop_reset,
  output logic [19:0] out_overshoot_rate
);

  localparam int unsigned PW = pfchc_pkg::PROD_W;
  localparam logic [15:0] PMT = 16'(PEAK_MAX_TIME);

  // sequencer codes
  localparam logic [2:0] ST_WAIT = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_POST = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  // configuration registers
  logic signed [15:0] setpoint_r;
  logic [9:0]  idle_diff_r, peak_diff_r;
  logic [15:0] cool_min_off_r, heat_min_off_r, cool_min_on_r, cool_max_on_r;
  logic [15:0] peak_max_wait_r;

  // controller state
  logic [1:0]  mode_r, before_r;
  logic [19:0] rate_r;
  logic signed [15:0] pred_peak_r;
  logic [31:0] stop_r, start_r;
  logic [7:0]  heater_r;
  logic        loop_rst_r;

  // latched request
  logic [31:0] now_r;
  logic signed [15:0] fridge_r, beer_r, target_r;
  logic        peak_r, fresh_r;
  logic [6:0]  duty_r;

  // serial arithmetic unit
  logic [2:0]  state_r, state_nxt;
  logic [1:0]  op_r;
  logic [5:0]  cnt_r;
  logic [PW-1:0] mul_a_r, acc_r, quo_r;
  logic [15:0] mul_b_r, div_r, rem_r;
  logic        out_valid_r;

  assign in_stall  = (state_r != ST_WAIT);
  assign out_valid = out_valid_r;

  // band edges and elapsed times, all from registered values
  logic signed [17:0] hi, lo;
  logic signed [31:0] run, off;
  logic signed [16:0] err;
  logic [16:0] mag;
  logic [18:0] f_raw;
  logic [15:0] f_val;
  logic [15:0] t_run;
  logic signed [PW+1:0] pk;
  logic [16:0] rem_sh;
  logic        rem_ge;
  logic        load_out;

  assign hi  = 18'(target_r) + $signed({8'd0, idle_diff_r});
  assign lo  = 18'(target_r) - $signed({8'd0, idle_diff_r});
  assign run = $signed(now_r - start_r);
  assign off = $signed(now_r - stop_r);
  assign err = 17'(pred_peak_r) - 17'(fridge_r);
  assign mag = err[16] ? 17'(-err) : 17'(err);
  assign f_raw = pfchc_pkg::F_BASE + 19'(mag) + 19'({mag, 1'b0});
  assign f_val = (f_raw > pfchc_pkg::F_CAP) ? 16'(pfchc_pkg::F_CAP) : f_raw[15:0];
  // run is non-negative whenever the cap is used
  assign t_run = (run < $signed({16'd0, PMT})) ? run[15:0] : PMT;
  assign pk    = (PW+2)'(fridge_r) - $signed({2'b00, quo_r});
  // restoring divider step
  assign rem_sh = {rem_r, quo_r[PW-1]};
  assign rem_ge = rem_sh >= {1'b0, div_r};
  assign load_out = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_WAIT: if (in_valid) state_nxt = ST_EVAL;
      ST_EVAL: begin
        state_nxt = ST_OUT;
        if (mode_r == pfchc_pkg::MODE_COOL) begin
          if (run >= $signed({16'd0, cool_min_on_r}) && !(18'(fridge_r) < lo))
            state_nxt = ST_MUL;
        end else if (mode_r != pfchc_pkg::MODE_HEAT &&
                     before_r == pfchc_pkg::MODE_COOL) begin
          if ((peak_r || off >= $signed({16'd0, peak_max_wait_r})) &&
              mag > 17'(peak_diff_r))
            state_nxt = ST_MUL;
        end
      end
      ST_MUL:  if (cnt_r == 6'(pfchc_pkg::MUL_B_W - 1)) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 6'(PW - 1)) state_nxt = ST_POST;
      ST_POST: state_nxt = ST_OUT;
      ST_OUT:  if (load_out) state_nxt = ST_WAIT;
      default: state_nxt = ST_WAIT;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r      <= 16'sd2000;
      idle_diff_r     <= 10'd50;
      peak_diff_r     <= 10'd50;
      cool_min_off_r  <= 16'd600;
      heat_min_off_r  <= 16'd600;
      cool_min_on_r   <= 16'd180;
      cool_max_on_r   <= 16'd2700;
      peak_max_wait_r <= 16'd1800;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pfchc_pkg::REG_SETPOINT:      setpoint_r      <= $signed(cfg_wdata);
        pfchc_pkg::REG_IDLE_DIFF:     idle_diff_r     <= cfg_wdata[9:0];
        pfchc_pkg::REG_PEAK_DIFF:     peak_diff_r     <= cfg_wdata[9:0];
        pfchc_pkg::REG_COOL_MIN_OFF:  cool_min_off_r  <= cfg_wdata;
        pfchc_pkg::REG_HEAT_MIN_OFF:  heat_min_off_r  <= cfg_wdata;
        pfchc_pkg::REG_COOL_MIN_ON:   cool_min_on_r   <= cfg_wdata;
        pfchc_pkg::REG_COOL_MAX_ON:   cool_max_on_r   <= cfg_wdata;
        pfchc_pkg::REG_PEAK_MAX_WAIT: peak_max_wait_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // request latch and serial datapath, no reset needed
  always_ff @(posedge clk) begin
    if (state_r == ST_WAIT && in_valid) begin
      now_r    <= in_now_seconds;
      fridge_r <= in_fridge_temp;
      beer_r   <= in_beer_temp;
      target_r <= in_target_temp;
      peak_r   <= in_peak_seen;
      duty_r   <= in_heat_duty;
      fresh_r  <= in_duty_fresh;
    end
    unique case (state_r)
      ST_EVAL: begin
        cnt_r   <= '0;
        acc_r   <= '0;
        mul_a_r <= PW'(rate_r);
        if (mode_r == pfchc_pkg::MODE_COOL) begin
          // predicted drop = min(run, cap) * rate / 36000
          op_r    <= pfchc_pkg::OP_DROP;
          mul_b_r <= t_run;
          div_r   <= pfchc_pkg::DIV_DROP;
        end else if (!err[16]) begin
          // peak came out no warmer than predicted: scale up
          op_r    <= pfchc_pkg::OP_UP;
          mul_b_r <= f_val;
          div_r   <= pfchc_pkg::DIV_SCALE;
        end else begin
          op_r    <= pfchc_pkg::OP_DOWN;
          mul_b_r <= pfchc_pkg::DIV_SCALE;
          div_r   <= f_val;
        end
      end
      ST_MUL: begin
        // one multiplier bit a cycle
        if (mul_b_r[0]) acc_r <= acc_r + mul_a_r;
        mul_a_r <= {mul_a_r[PW-2:0], 1'b0};
        mul_b_r <= {1'b0, mul_b_r[15:1]};
        if (cnt_r == 6'(pfchc_pkg::MUL_B_W - 1)) begin
          cnt_r <= '0;
          rem_r <= '0;
          quo_r <= mul_b_r[0] ? acc_r + mul_a_r : acc_r;
        end else begin
          cnt_r <= cnt_r + 6'd1;
        end
      end
      ST_DIV: begin
        // one quotient bit a cycle
        cnt_r <= cnt_r + 6'd1;
        rem_r <= rem_ge ? 16'(rem_sh - {1'b0, div_r}) : rem_sh[15:0];
        quo_r <= {quo_r[PW-2:0], rem_ge};
      end
      default: ;
    endcase
  end

  // controller state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WAIT;
      mode_r      <= pfchc_pkg::MODE_IDLE;
      before_r    <= pfchc_pkg::MODE_IDLE;
      rate_r      <= pfchc_pkg::RATE_RESET;
      pred_peak_r <= '0;
      stop_r      <= '0;
      start_r     <= '0;
      heater_r    <= '0;
      loop_rst_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_WAIT: loop_rst_r <= 1'b0;
        ST_EVAL: begin
          if (mode_r == pfchc_pkg::MODE_COOL) begin
            // fridge already under the band: plain stop
            if (run >= $signed({16'd0, cool_min_on_r}) && 18'(fridge_r) < lo) begin
              stop_r   <= now_r;
              start_r  <= now_r;
              mode_r   <= pfchc_pkg::MODE_IDLE;
              before_r <= pfchc_pkg::MODE_IDLE;
            end
          end else if (mode_r == pfchc_pkg::MODE_HEAT) begin
            if (18'(fridge_r) > hi) begin
              heater_r   <= '0;
              loop_rst_r <= 1'b1;
              stop_r     <= now_r;
              start_r    <= now_r;
              mode_r     <= pfchc_pkg::MODE_IDLE;
              before_r   <= pfchc_pkg::MODE_IDLE;
            end else if (fresh_r) begin
              heater_r <= pfchc_pkg::heater_from_duty(duty_r);
            end
          end else if (before_r == pfchc_pkg::MODE_COOL) begin
            // awaiting the peak after a predicted stop
            if (peak_r || off >= $signed({16'd0, peak_max_wait_r})) begin
              start_r  <= now_r;
              before_r <= pfchc_pkg::MODE_IDLE;
            end
          end else if (before_r == pfchc_pkg::MODE_IDLE) begin
            if (18'(fridge_r) > hi && 17'(beer_r) > 17'(setpoint_r) + 17'sd5 &&
                off > $signed({16'd0, cool_min_off_r})) begin
              start_r <= now_r;
              mode_r  <= pfchc_pkg::MODE_COOL;
            end else if (18'(fridge_r) < lo &&
                         17'(beer_r) < 17'(setpoint_r) - 17'sd5 &&
                         off > $signed({16'd0, heat_min_off_r})) begin
              loop_rst_r <= 1'b1;
              start_r    <= now_r;
              mode_r     <= pfchc_pkg::MODE_HEAT;
            end
          end
        end
        ST_POST: begin
          unique case (op_r)
            pfchc_pkg::OP_DROP: begin
              if (pk < (PW+2)'(lo))
                pred_peak_r <= (pk < -(PW+2)'(32768)) ? -16'sd32768 : pk[15:0];
              // max on time wins over a predicted stop, no peak wait then
              if (run > $signed({16'd0, cool_max_on_r})) begin
                stop_r   <= now_r;
                start_r  <= now_r;
                mode_r   <= pfchc_pkg::MODE_IDLE;
                before_r <= pfchc_pkg::MODE_IDLE;
              end else if (pk < (PW+2)'(lo)) begin
                stop_r   <= now_r;
                start_r  <= now_r;
                mode_r   <= pfchc_pkg::MODE_IDLE;
                before_r <= pfchc_pkg::MODE_COOL;
              end
            end
            pfchc_pkg::OP_UP:
              rate_r <= (quo_r > PW'(pfchc_pkg::RATE_MAX)) ? pfchc_pkg::RATE_MAX
                                                           : quo_r[19:0];
            default:
              rate_r <= (quo_r < PW'(pfchc_pkg::RATE_MIN)) ? pfchc_pkg::RATE_MIN
                                                           : quo_r[19:0];
          endcase
        end
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_mode            <= mode_r;
      out_prior_mode      <= before_r;
      out_compressor_on   <= (mode_r == pfchc_pkg::MODE_COOL);
      out_heater_level    <= heater_r;
      out_heat_loop_reset <= loop_rst_r;
      out_overshoot_rate  <= rate_r;
    end
  end

endmodule

FILE: hw/rtl/pfchc_checker.sv
`include "predictive_fridge_cool_heat_control_assert.svh"

module pfchc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_mode,
  input logic        out_compressor_on,
  input logic [7:0]  out_heater_level,
  input logic [19:0] out_overshoot_rate
);

  // compressor drive follows the cool state
  `PFCH_ASSERT_NOW(a_comp_mode, out_valid, out_compressor_on == (out_mode == pfchc_pkg::MODE_COOL))
  // heater level is cleared outside heat
  `PFCH_ASSERT_NOW(a_heat_zero, out_valid && out_mode != pfchc_pkg::MODE_HEAT, out_heater_level == 8'd0)
  // estimator stays within its floor and ceiling
  `PFCH_ASSERT_NOW(a_rate_rng, out_valid, out_overshoot_rate >= 20'd50 && out_overshoot_rate <= 20'd1000000)
  // one request at a time
  `PFCH_ASSERT_NEXT(a_one_req, in_valid && !in_stall, in_stall)
  // a stalled result stays
  `PFCH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

endmodule

bind predictive_fridge_cool_heat_control pfchc_checker u_pfchc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_mode           (out_mode),
  .out_compressor_on  (out_compressor_on),
  .out_heater_level   (out_heater_level),
  .out_overshoot_rate (out_overshoot_rate)
);
